// ----- sv/tksl_pkg.sv -----
// ----------------------------------------------------------------------------
// tksl_pkg
// Shared types and constants of the sorted top-k record list.
// ----------------------------------------------------------------------------
package tksl_pkg;

  // table geometry
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int RANK_W     = 5;

  // label byte 15 is always stored as zero
  localparam logic [63:0] LABEL_TAIL_CLEAR = 64'hFFFF_FFFF_FFFF_FF00;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // one stored record
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] rows;
    logic [31:0] level;
    logic [31:0] duration;
    logic [31:0] stamp;
    logic [63:0] label_first;
    logic [63:0] label_second;
  } rec_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic ins_en;
    rec_t rec;
  } bcast_t;

endpackage

// ----- sv/tksl_cell.sv -----
// ----------------------------------------------------------------------------
// tksl_cell
// One slot of the list: compares the broadcast key with its own and on an
// insert either keeps its record, takes the new one or takes its neighbor's.
// ----------------------------------------------------------------------------
module tksl_cell
  import tksl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  bcast_t bcast,
  input  logic   prev_gt,
  input  rec_t   prev_rec,
  output rec_t   rec_o,
  output logic   gt_o
);

  rec_t rec_r;
  rec_t rec_nxt;

  // new key sorts below this slot when it is strictly smaller
  assign gt_o  = bcast.rec.key < rec_r.key;
  assign rec_o = rec_r;

  // slot update on insert
  always_comb begin
    rec_nxt = rec_r;
    if (bcast.ins_en && !gt_o) begin
      if (prev_gt) begin
        rec_nxt = bcast.rec;
      end else begin
        rec_nxt = prev_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

endmodule

// ----- sv/top_k_sorted_insert_list_unit.sv -----
// ----------------------------------------------------------------------------
// top_k_sorted_insert_list_unit
// Sorted top-k record list built from a chain of compare and shift cells.
// ----------------------------------------------------------------------------
// Usage
//   Input beats carry an opcode (insert, query rank, read record), a key,
//   four payload words, a 16-byte label and a read index. Every input beat
//   yields exactly one output beat with rank, placed and the record fields.
//   All cells compare the key in parallel; the rank is the edge of the
//   resulting thermometer and an insert shifts the lower slots down one cell
//   in the same cycle. A read selects one cell through a mux.
//   Output: each result is registered in the output register.
//   Throughput: one beat per cycle while out_stall is low, set by the cell
//   update and the output register.
//   Stall: the output register holds its beat while out_stall is high; a new
//   input beat is taken only when that register is empty or drains in the
//   same cycle, so in_stall follows out_stall while a beat waits.
//   Reset: synchronous, active low; every slot clears to zero and the output
//   register empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_list_unit
  import tksl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [31:0]       in_key_value,
  input  logic [31:0]       in_payload_rows,
  input  logic [31:0]       in_payload_level,
  input  logic [31:0]       in_payload_duration,
  input  logic [31:0]       in_payload_stamp,
  input  logic [63:0]       in_label_first_half,
  input  logic [63:0]       in_label_second_half,
  input  logic [3:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RANK_W-1:0] out_rank,
  output logic              out_placed,
  output logic [31:0]       out_key,
  output logic [31:0]       out_rows,
  output logic [31:0]       out_level,
  output logic [31:0]       out_duration,
  output logic [31:0]       out_stamp,
  output logic [63:0]       out_label_first,
  output logic [63:0]       out_label_second
);

  logic              accept;
  bcast_t            bcast;
  rec_t              recs [LIST_DEPTH];
  logic [LIST_DEPTH:0] gt_ext;
  logic [RANK_W-1:0] find_rank;
  logic              rank_hit;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_ok;

  logic              out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              placed_r, placed_nxt;
  rec_t              orec_r, orec_nxt;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // broadcast beat to the cells
  always_comb begin
    bcast.ins_en            = accept && (in_opcode == OP_INSERT);
    bcast.rec.key           = in_key_value;
    bcast.rec.rows          = in_payload_rows;
    bcast.rec.level         = in_payload_level;
    bcast.rec.duration      = in_payload_duration;
    bcast.rec.stamp         = in_payload_stamp;
    bcast.rec.label_first   = in_label_first_half;
    bcast.rec.label_second  = in_label_second_half & LABEL_TAIL_CLEAR;
  end

  // chain of cells, slot 0 holds the largest key
  assign gt_ext[0] = 1'b1;
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    tksl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bcast    (bcast),
      .prev_gt  (gt_ext[i]),
      .prev_rec ((i == 0) ? bcast.rec : recs[(i == 0) ? 0 : i - 1]),
      .rec_o    (recs[i]),
      .gt_o     (gt_ext[i + 1])
    );
  end

  // rank is the edge of the compare thermometer
  always_comb begin
    find_rank = '0;
    for (int i = 1; i <= LIST_DEPTH; i++) begin
      if (gt_ext[i] && ((i == LIST_DEPTH) || !gt_ext[(i == LIST_DEPTH) ? i : i + 1])) begin
        find_rank = find_rank | RANK_W'(i);
      end
    end
  end
  assign rank_hit = find_rank != RANK_W'(LIST_DEPTH);

  // read select
  assign rd_idx = IDX_W'(in_read_index);
  assign rd_ok  = 32'(in_read_index) < 32'(LIST_DEPTH);

  // result of the accepted beat
  always_comb begin
    rank_nxt   = rank_r;
    placed_nxt = placed_r;
    orec_nxt   = orec_r;
    if (accept) begin
      rank_nxt   = RANK_W'(LIST_DEPTH);
      placed_nxt = 1'b0;
      orec_nxt   = '0;
      unique case (in_opcode)
        OP_INSERT: begin
          rank_nxt   = find_rank;
          placed_nxt = rank_hit;
        end
        OP_QUERY: begin
          rank_nxt = find_rank;
        end
        OP_READ: begin
          if (rd_ok) begin
            rank_nxt = RANK_W'(in_read_index);
            orec_nxt = recs[rd_idx];
          end
        end
        default: begin
          rank_nxt = RANK_W'(LIST_DEPTH);
        end
      endcase
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    rank_r   <= rank_nxt;
    placed_r <= placed_nxt;
    orec_r   <= orec_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_rank         = rank_r;
  assign out_placed       = placed_r;
  assign out_key          = orec_r.key;
  assign out_rows         = orec_r.rows;
  assign out_level        = orec_r.level;
  assign out_duration     = orec_r.duration;
  assign out_stamp        = orec_r.stamp;
  assign out_label_first  = orec_r.label_first;
  assign out_label_second = orec_r.label_second;

  // keys stay in descending order
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      if (recs[i].key > recs[i - 1].key) begin
        sorted_ok = 1'b0;
      end
    end
  end

  // checks
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
    else $error("slot keys out of order");

  a_placed_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_placed |-> out_rank < RANK_W'(LIST_DEPTH))
    else $error("placed record without a slot");

  a_insert_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == OP_INSERT) && rank_hit && (find_rank == '0)
    |=> recs[0].key == $past(in_key_value))
    else $error("insert at head not stored");

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(rank_r) && $stable(placed_r))
    else $error("waiting beat lost");

endmodule
